// File: hdl/triangle_face_normal_defines.svh
// Assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFN_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");
`define TFN_ASSERT_DELAY(label, clk, rst, a, n, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##n (b)) \
      else $error("assertion failed: label");
`else
`define TFN_ASSERT_IMPLY(label, clk, rst, a, b)
`define TFN_ASSERT_DELAY(label, clk, rst, a, n, b)
`endif
`endif

// File: hdl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths and the lane type shared by the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int MAG_BITS = 34;
   localparam int Q_BITS = 15;
   localparam int FRAC_SHIFT = 28;
   localparam int MSQ_W = 2 * MAG_BITS;
   localparam int S_W = MSQ_W + 2;
   localparam int RHS_W = MSQ_W + FRAC_SHIFT;
   localparam int P_W = RHS_W + 6;
   localparam int QS_W = S_W + Q_BITS + 1;
   localparam int OUT_W = 16;

   typedef struct packed {
      logic [P_W-1:0] p;
      logic [QS_W-1:0] qs;
      logic [Q_BITS-1:0] q;
      logic [RHS_W-1:0] rhs;
      logic neg;
   } lane_type;
endpackage

// File: hdl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edges, partial products and cross product: three register stages.
// ----------------------------------------------------------------------------
module tfn_cross #(
   parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z,
   input  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z,
   input  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z,
   output logic out_valid,
   output logic signed [2*COORD_WIDTH+2:0] cross_x, cross_y, cross_z
);
   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;
   localparam int CW = PW + 1;

   logic v1_ff, v2_ff, v3_ff;
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [PW-1:0] pr_ff [6];
   logic signed [CW-1:0] cr_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_ff[0] <= EW'(a_x) - EW'(b_x);
      e1_ff[1] <= EW'(a_y) - EW'(b_y);
      e1_ff[2] <= EW'(a_z) - EW'(b_z);
      e2_ff[0] <= EW'(a_x) - EW'(c_x);
      e2_ff[1] <= EW'(a_y) - EW'(c_y);
      e2_ff[2] <= EW'(a_z) - EW'(c_z);
      pr_ff[0] <= PW'(e1_ff[1]) * PW'(e2_ff[2]);
      pr_ff[1] <= PW'(e1_ff[2]) * PW'(e2_ff[1]);
      pr_ff[2] <= PW'(e1_ff[2]) * PW'(e2_ff[0]);
      pr_ff[3] <= PW'(e1_ff[0]) * PW'(e2_ff[2]);
      pr_ff[4] <= PW'(e1_ff[0]) * PW'(e2_ff[1]);
      pr_ff[5] <= PW'(e1_ff[1]) * PW'(e2_ff[0]);
      cr_ff[0] <= CW'(pr_ff[0]) - CW'(pr_ff[1]);
      cr_ff[1] <= CW'(pr_ff[2]) - CW'(pr_ff[3]);
      cr_ff[2] <= CW'(pr_ff[4]) - CW'(pr_ff[5]);
   end

   assign out_valid = v3_ff;
   assign cross_x = cr_ff[0];
   assign cross_y = cr_ff[1];
   assign cross_z = cr_ff[2];
endmodule

// File: hdl/tfn_norm.sv
// ----------------------------------------------------------------------------
// tfn_norm
// Magnitude scaling, squares and squared length: three register stages.
// ----------------------------------------------------------------------------
module tfn_norm #(
   parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [2*COORD_WIDTH+2:0] cross_x, cross_y, cross_z,
   output logic out_valid,
   output logic out_deg,
   output logic [tfn_pkg::S_W-1:0] sum_sq,
   output tfn_pkg::lane_type lane [3]
);
   localparam int CW = 2 * COORD_WIDTH + 3;
   localparam int MB = tfn_pkg::MAG_BITS;
   localparam int XW = (CW > MB) ? CW : MB;
   localparam int LW = $clog2(XW + 1);

   logic v4_ff, v5_ff, v6_ff;
   logic [XW-1:0] mag_in [3];
   logic [XW-1:0] any_in;
   logic [LW-1:0] len_in, sh_in;
   logic [MB-1:0] m_ff [3];
   logic [2:0] neg4_ff, neg5_ff, neg6_ff;
   logic deg4_ff, deg5_ff, deg6_ff;
   logic [tfn_pkg::MSQ_W-1:0] msq_ff [3];
   logic [tfn_pkg::S_W-1:0] s_ff;
   logic [tfn_pkg::RHS_W-1:0] rhs_ff [3];

   always_comb begin
      mag_in[0] = cross_x[CW-1] ? XW'(-cross_x) : XW'(cross_x);
      mag_in[1] = cross_y[CW-1] ? XW'(-cross_y) : XW'(cross_y);
      mag_in[2] = cross_z[CW-1] ? XW'(-cross_z) : XW'(cross_z);
      any_in = mag_in[0] | mag_in[1] | mag_in[2];
      len_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (any_in[i]) len_in = LW'(i + 1);
      end
      // keep the largest magnitude within MAG_BITS
      sh_in = (len_in > LW'(MB)) ? len_in - LW'(MB) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         m_ff[i] <= MB'(mag_in[i] >> sh_in);
         msq_ff[i] <= tfn_pkg::MSQ_W'(m_ff[i]) * tfn_pkg::MSQ_W'(m_ff[i]);
         rhs_ff[i] <= tfn_pkg::RHS_W'(msq_ff[i]) << tfn_pkg::FRAC_SHIFT;
      end
      neg4_ff <= {cross_z[CW-1], cross_y[CW-1], cross_x[CW-1]};
      deg4_ff <= (any_in == '0);
      neg5_ff <= neg4_ff;
      deg5_ff <= deg4_ff;
      neg6_ff <= neg5_ff;
      deg6_ff <= deg5_ff;
      s_ff <= tfn_pkg::S_W'(msq_ff[0]) + tfn_pkg::S_W'(msq_ff[1])
            + tfn_pkg::S_W'(msq_ff[2]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lane[i].p = '0;
         lane[i].qs = '0;
         lane[i].q = '0;
         lane[i].rhs = rhs_ff[i];
         lane[i].neg = neg6_ff[i];
      end
   end

   assign out_valid = v6_ff;
   assign out_deg = deg6_ff;
   assign sum_sq = s_ff;
endmodule

// File: hdl/tfn_quot_stage.sv
// ----------------------------------------------------------------------------
// tfn_quot_stage
// One bit of the unit quotient for all three lanes, kept as running
// q*q*s and q*s so each trial is shifts and adds.
// ----------------------------------------------------------------------------
module tfn_quot_stage #(
   parameter int BIT = tfn_pkg::Q_BITS - 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic in_deg,
   input  logic [tfn_pkg::S_W-1:0] in_s,
   input  tfn_pkg::lane_type in_lane [3],
   output logic out_valid,
   output logic out_deg,
   output logic [tfn_pkg::S_W-1:0] out_s,
   output tfn_pkg::lane_type out_lane [3]
);
   logic valid_ff, deg_ff;
   logic [tfn_pkg::S_W-1:0] s_ff;
   tfn_pkg::lane_type lane_ff [3];
   tfn_pkg::lane_type lane_in [3];
   logic [tfn_pkg::P_W-1:0] cand_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 2^(2b) s
         cand_in[i] = in_lane[i].p
                    + (tfn_pkg::P_W'(in_lane[i].qs) << (BIT + 1))
                    + (tfn_pkg::P_W'(in_s) << (2 * BIT));
         lane_in[i] = in_lane[i];
         if (cand_in[i] <= tfn_pkg::P_W'(in_lane[i].rhs)) begin
            lane_in[i].p = cand_in[i];
            lane_in[i].qs = in_lane[i].qs + (tfn_pkg::QS_W'(in_s) << BIT);
            lane_in[i].q[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      deg_ff <= in_deg;
      s_ff <= in_s;
      lane_ff <= lane_in;
   end

   assign out_valid = valid_ff;
   assign out_deg = deg_ff;
   assign out_s = s_ff;
   assign out_lane = lane_ff;
endmodule

// File: hdl/triangle_face_normal.sv
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle, signed Q1.14, fully pipelined.
// ----------------------------------------------------------------------------
// channel   ports                          direction
// request   start, busy, req_a_x..c_z      in  (busy is always low)
// response  rsp_strobe, rsp_unit_*, rsp_degenerate   out
//
// One item per cycle; every item passes from accept to strobe through
// 3 cross product stages, 3 scaling stages, 15 quotient bit stages and the
// output register. Reset clears only the valid bits. Nothing stalls: the
// quotient chain is a fixed pipeline and the receiver always takes results.
`include "triangle_face_normal_defines.svh"
module triangle_face_normal #(
   parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_WIDTH-1:0] req_a_x, req_a_y, req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x, req_b_y, req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x, req_c_y, req_c_z,
   output logic rsp_strobe,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_x,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_y,
   output logic signed [tfn_pkg::OUT_W-1:0] rsp_unit_z,
   output logic rsp_degenerate
);
   localparam int NQ = tfn_pkg::Q_BITS;
   localparam int LATENCY = 6 + NQ + 1;
   localparam int OW = tfn_pkg::OUT_W;

   logic accept;
   logic cr_valid;
   logic signed [2*COORD_WIDTH+2:0] cr_x, cr_y, cr_z;
   logic st_valid [NQ+1];
   logic st_deg [NQ+1];
   logic [tfn_pkg::S_W-1:0] st_s [NQ+1];
   tfn_pkg::lane_type st_lane [NQ+1][3];
   logic strobe_ff, deg_ff;
   logic signed [OW-1:0] nrm_ff [3];
   logic signed [OW-1:0] nrm_in [3];

   assign busy = 1'b0;
   assign accept = start && !busy;

   tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
      .clock(clock), .reset(reset), .in_valid(accept),
      .a_x(req_a_x), .a_y(req_a_y), .a_z(req_a_z),
      .b_x(req_b_x), .b_y(req_b_y), .b_z(req_b_z),
      .c_x(req_c_x), .c_y(req_c_y), .c_z(req_c_z),
      .out_valid(cr_valid), .cross_x(cr_x), .cross_y(cr_y), .cross_z(cr_z)
   );

   tfn_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
      .clock(clock), .reset(reset), .in_valid(cr_valid),
      .cross_x(cr_x), .cross_y(cr_y), .cross_z(cr_z),
      .out_valid(st_valid[0]), .out_deg(st_deg[0]), .sum_sq(st_s[0]),
      .lane(st_lane[0])
   );

   for (genvar g = 0; g < NQ; g++) begin : g_quot
      tfn_quot_stage #(.BIT(NQ - 1 - g)) u_stage (
         .clock(clock), .reset(reset),
         .in_valid(st_valid[g]), .in_deg(st_deg[g]), .in_s(st_s[g]),
         .in_lane(st_lane[g]),
         .out_valid(st_valid[g+1]), .out_deg(st_deg[g+1]), .out_s(st_s[g+1]),
         .out_lane(st_lane[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_in[i] = st_lane[NQ][i].neg ? -OW'(st_lane[NQ][i].q)
                                        : OW'(st_lane[NQ][i].q);
         // drop the quotient of a zero-length normal
         if (st_deg[NQ]) nrm_in[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= st_valid[NQ];
      end
   end

   always_ff @(posedge clock) begin
      deg_ff <= st_deg[NQ];
      nrm_ff <= nrm_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_degenerate = deg_ff;
   assign rsp_unit_x = nrm_ff[0];
   assign rsp_unit_y = nrm_ff[1];
   assign rsp_unit_z = nrm_ff[2];

   `TFN_ASSERT_DELAY(a_latency, clock, reset, accept, LATENCY, rsp_strobe)
   `TFN_ASSERT_IMPLY(a_deg_zero, clock, reset, rsp_strobe && rsp_degenerate,
      rsp_unit_x == 0 && rsp_unit_y == 0 && rsp_unit_z == 0)
   `TFN_ASSERT_IMPLY(a_range, clock, reset, rsp_strobe,
      rsp_unit_x <= 16384 && rsp_unit_x >= -16384 && rsp_unit_y <= 16384
      && rsp_unit_y >= -16384 && rsp_unit_z <= 16384 && rsp_unit_z >= -16384)
endmodule
